>>> hdl/nearest_centroid_search_assert.svh
// Assertion macros shared by the nearest-centroid search RTL.
`ifndef NEAREST_CENTROID_SEARCH_ASSERT_SVH
`define NEAREST_CENTROID_SEARCH_ASSERT_SVH

// Same-cycle implication, checked on aclk while out of reset.
`define NCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk while out of reset.
`define NCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/ncs_pkg.sv
// Package: shared types, codes and defaults of the nearest-centroid search.
`timescale 1ns / 1ps

package ncs_pkg;

    localparam int unsigned MAX_CLUSTERS_DEF = 64;
    localparam int unsigned MAX_DIM_DEF      = 256;
    localparam int unsigned VALUE_WIDTH_DEF  = 16;

    // Fixed field widths of the stream items and registers
    localparam int unsigned CLUSTER_W  = 6;
    localparam int unsigned ELEMENT_W  = 8;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned DIST_W     = 48;
    localparam int unsigned NCLUST_W   = 7;
    localparam int unsigned VLEN_W     = 9;
    localparam int unsigned CFG_DATA_W = 9;
    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned M_TDATA_W  = 56;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    // Magnitudes at or above 2^SQ_SAT_BIT square past the distance range
    localparam int unsigned SQ_SAT_BIT = 24;

    // Configuration register indexes
    localparam logic CFG_CLUSTER_COUNT = 1'b0;
    localparam logic CFG_VECTOR_LENGTH = 1'b1;

    // Operation codes carried in tuser
    localparam logic OP_CENTROID = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    // Flags that travel beside each element through the distance pipeline
    typedef struct packed {
        logic                valid;
        logic                first;
        logic                last;
        logic [NCLUST_W-1:0] cluster;
    } tag_t;

endpackage

>>> hdl/nearest_centroid_search.sv
// Top level: nearest-centroid search by squared Euclidean distance.
`timescale 1ns / 1ps
//
//  Channel   Dir  Fields (tdata low bit up / tuser / tlast)
//  s_*       in   cluster_index[5:0], element_index[13:6], value[29:14] / operation / last
//  m_*       out  best_cluster[5:0], best_distance[53:6] / - / -
//  cfg_*     in   index 0 cluster_count, index 1 vector_length
//
//  A centroid write or a query element without tlast leaves the block idle.
//  A query element with tlast starts a search over nc active centroids of len
//  elements each: one shared multiply-accumulate works one element per cycle
//  from the single read port of the centroid memory.
//  s_tready is low during the search; a result waits in the output register.
//  Reset (aresetn low, synchronous) clears control, loads config defaults; data registers and memories stay.

module nearest_centroid_search #(
    parameter int unsigned MAX_CLUSTERS = ncs_pkg::MAX_CLUSTERS_DEF,
    parameter int unsigned MAX_DIM      = ncs_pkg::MAX_DIM_DEF,
    parameter int unsigned VALUE_WIDTH  = ncs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_wr_en,
    input  logic                            cfg_addr,
    input  logic [ncs_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: cluster_index[5:0], element_index[13:6], value[29:14], zero pad
    input  logic [ncs_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: operation[0]
    input  logic [0:0]                      s_tuser,
    input  logic                            s_tlast,
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: best_cluster[5:0], best_distance[53:6], zero pad
    output logic [ncs_pkg::M_TDATA_W-1:0]   m_tdata
);

    import ncs_pkg::*;

    `include "nearest_centroid_search_assert.svh"

    localparam int unsigned AW = (MAX_CLUSTERS * MAX_DIM > 1) ?
                                 $clog2(MAX_CLUSTERS * MAX_DIM) : 1;
    localparam int unsigned DW = $clog2(MAX_DIM);
    localparam int unsigned VW = VALUE_WIDTH;
    localparam int unsigned MW = (VW + 1 < SQ_SAT_BIT) ? VW + 1 : SQ_SAT_BIT;

    // Configuration
    logic [NCLUST_W-1:0] cluster_count_reg;
    logic [VLEN_W-1:0]   vector_length_reg;

    // Input field unpacking
    logic                 in_accept;
    logic                 in_op;
    logic [CLUSTER_W-1:0] in_cluster;
    logic [ELEMENT_W-1:0] in_element;
    logic [VALUE_W-1:0]   in_value;
    logic [VW+VALUE_W-1:0] value_ext;
    logic [VW-1:0]        store_word;
    logic [AW-1:0]        c_wr_addr;
    logic                 c_wr_ok;
    logic                 q_wr_ok;

    // Memories
    logic [VW-1:0] centroid_mem [MAX_CLUSTERS * MAX_DIM];
    logic [VW-1:0] query_mem    [MAX_DIM];

    // Sequencer
    state_t              state_reg;
    logic [NCLUST_W-1:0] k_reg;
    logic [VLEN_W-1:0]   d_reg;
    logic [NCLUST_W-1:0] nc_m1_reg;
    logic [VLEN_W-1:0]   len_m1_reg;
    logic [AW-1:0]       base_reg;
    logic [AW-1:0]       caddr_reg;
    logic [NCLUST_W-1:0] nc_eff;
    logic [VLEN_W-1:0]   len_eff;
    logic                elem_last;
    logic                clus_last;
    tag_t                issue_tag;

    // Distance pipeline
    tag_t                 tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic signed [VW-1:0] c_rd_reg, q_rd_reg;
    logic signed [VW:0]   diff;
    logic [VW:0]          mag;
    logic [MW-1:0]        mag_reg;
    logic                 sat_reg;
    logic [DIST_W-1:0]    sq_reg;
    logic [DIST_W-1:0]    acc_reg, acc_next;
    logic [DIST_W:0]      acc_sum;
    logic [DIST_W-1:0]    best_d_reg;
    logic [NCLUST_W-1:0]  best_k_reg;
    logic                 pipe_busy;

    // Output register
    logic                 m_tvalid_reg;
    logic [CLUSTER_W-1:0] m_cluster_reg;
    logic [DIST_W-1:0]    m_dist_reg;

    assign in_accept  = s_tvalid && s_tready;
    assign in_op      = s_tuser[0];
    assign in_cluster = s_tdata[CLUSTER_W-1:0];
    assign in_element = s_tdata[CLUSTER_W+ELEMENT_W-1:CLUSTER_W];
    assign in_value   = s_tdata[CLUSTER_W+ELEMENT_W+VALUE_W-1:CLUSTER_W+ELEMENT_W];

    // Cut to VALUE_WIDTH bits; the stored word is read back as signed
    assign value_ext  = {{VW{1'b0}}, in_value};
    assign store_word = value_ext[VW-1:0];

    assign c_wr_addr = AW'(32'(in_cluster) * MAX_DIM + 32'(in_element));
    assign c_wr_ok   = (32'(in_cluster) < MAX_CLUSTERS) && (32'(in_element) < MAX_DIM);
    assign q_wr_ok   = 32'(in_element) < MAX_DIM;

    assign s_tready = (state_reg == ST_IDLE);

    // Config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_count_reg <= NCLUST_W'(1);
            vector_length_reg <= VLEN_W'(256);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_CLUSTER_COUNT: cluster_count_reg <= cfg_wr_data[NCLUST_W-1:0];
                CFG_VECTOR_LENGTH: vector_length_reg <= cfg_wr_data[VLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Memory writes from the input stream, reads from the sequencer
    always_ff @(posedge aclk) begin
        if (in_accept && in_op == OP_CENTROID && c_wr_ok) begin
            centroid_mem[c_wr_addr] <= store_word;
        end
        c_rd_reg <= centroid_mem[caddr_reg];
    end

    always_ff @(posedge aclk) begin
        if (in_accept && in_op == OP_QUERY && q_wr_ok) begin
            query_mem[DW'(in_element)] <= store_word;
        end
        q_rd_reg <= query_mem[DW'(d_reg)];
    end

    // Clamp the searched extent to the storage
    assign nc_eff  = (32'(cluster_count_reg) > MAX_CLUSTERS) ?
                     NCLUST_W'(MAX_CLUSTERS) : cluster_count_reg;
    assign len_eff = (32'(vector_length_reg) > MAX_DIM) ?
                     VLEN_W'(MAX_DIM) : vector_length_reg;

    assign elem_last = (d_reg == len_m1_reg);
    assign clus_last = (k_reg == nc_m1_reg);

    always_comb begin
        issue_tag         = '0;
        issue_tag.valid   = (state_reg == ST_RUN);
        issue_tag.first   = (d_reg == '0);
        issue_tag.last    = elem_last;
        issue_tag.cluster = k_reg;
    end

    assign pipe_busy = tag1_reg.valid || tag2_reg.valid || tag3_reg.valid || tag4_reg.valid;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            k_reg        <= '0;
            d_reg        <= '0;
            base_reg     <= '0;
            caddr_reg    <= '0;
        end else begin
            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept && in_op == OP_QUERY && s_tlast) begin
                        k_reg      <= '0;
                        d_reg      <= '0;
                        base_reg   <= '0;
                        caddr_reg  <= '0;
                        nc_m1_reg  <= nc_eff - NCLUST_W'(1);
                        len_m1_reg <= len_eff - VLEN_W'(1);
                        if (nc_eff == '0 || len_eff == '0) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (elem_last) begin
                        d_reg     <= '0;
                        k_reg     <= k_reg + NCLUST_W'(1);
                        base_reg  <= base_reg + AW'(MAX_DIM);
                        caddr_reg <= base_reg + AW'(MAX_DIM);
                        if (clus_last) begin
                            state_reg <= ST_DRAIN;
                        end
                    end else begin
                        d_reg     <= d_reg + VLEN_W'(1);
                        caddr_reg <= caddr_reg + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // Hand over once the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_cluster_reg <= best_k_reg[CLUSTER_W-1:0];
                        m_dist_reg    <= best_d_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Distance pipeline: read, magnitude, square, accumulate, compare
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else begin
            tag1_reg <= issue_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    assign diff = {q_rd_reg[VW-1], q_rd_reg} - {c_rd_reg[VW-1], c_rd_reg};
    assign mag  = diff[VW] ? (VW+1)'(-diff) : (VW+1)'(diff);

    always_ff @(posedge aclk) begin
        mag_reg <= mag[MW-1:0];
        sat_reg <= (mag >> MW) != '0;
        sq_reg  <= sat_reg ? DIST_MAX : DIST_W'(mag_reg * mag_reg);
    end

    // Saturating running sum; restart on the first element of a centroid
    assign acc_sum  = {1'b0, acc_reg} + {1'b0, sq_reg};
    assign acc_next = tag3_reg.first ? sq_reg :
                      (acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0]);

    always_ff @(posedge aclk) begin
        if (tag3_reg.valid) begin
            acc_reg <= acc_next;
        end
    end

    // Strict less-than keeps the lower index on ties
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            best_d_reg <= '0;
            best_k_reg <= '0;
        end else if (tag4_reg.valid && tag4_reg.last) begin
            if (tag4_reg.cluster == '0 || acc_reg < best_d_reg) begin
                best_d_reg <= acc_reg;
                best_k_reg <= tag4_reg.cluster;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W-DIST_W-CLUSTER_W){1'b0}}, m_dist_reg, m_cluster_reg};

    `NCS_ASSERT_NOW(a_idle_pipe_empty, state_reg == ST_IDLE, !pipe_busy,
        "distance pipeline busy while idle")
    `NCS_ASSERT_NOW(a_issue_from_run, tag1_reg.valid, $past(state_reg == ST_RUN),
        "element issued outside the search")
    `NCS_ASSERT_NOW(a_result_from_done, $rose(m_tvalid_reg), $past(state_reg == ST_DONE),
        "result loaded without a finished search")
    `NCS_ASSERT_NEXT(a_run_leaves_on_last, state_reg == ST_RUN && elem_last && clus_last,
        state_reg == ST_DRAIN, "search did not stop after the last element")

endmodule

>>> sim/nearest_centroid_search_tb.sv
// Testbench: streams centroid and query elements into the search and checks each result.
`timescale 1ns / 1ps

module nearest_centroid_search_tb;
    import ncs_pkg::*;

    // Searches here stay small, so this is many times the slowest correct run
    localparam int unsigned LIMIT_CYCLES  = 500000;
    localparam int unsigned ITEM_TARGET   = 1530;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned TAIL_CYCLES   = 300;
    localparam int unsigned TABLE_DEPTH   = MAX_CLUSTERS_DEF * MAX_DIM_DEF;

    typedef struct packed {
        logic                 op;
        logic [CLUSTER_W-1:0] cluster;
        logic [ELEMENT_W-1:0] element;
        logic [VALUE_W-1:0]   value;
        logic                 last;
    } element_item_t;

    typedef struct packed {
        logic [CLUSTER_W-1:0] cluster;
        logic [DIST_W-1:0]    distance;
    } nearest_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_wr_en   = 1'b0;
    logic                  cfg_addr    = CFG_CLUSTER_COUNT;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid    = 1'b0;
    logic                  s_tready;
    // s_tdata: cluster_index[5:0], element_index[13:6], value[29:14], zero pad
    logic [S_TDATA_W-1:0]  s_tdata     = '0;
    // s_tuser: operation[0]
    logic [0:0]            s_tuser     = '0;
    logic                  s_tlast     = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready    = 1'b0;
    // m_tdata: best_cluster[5:0], best_distance[53:6], zero pad
    logic [M_TDATA_W-1:0]  m_tdata;

    nearest_centroid_search dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    element_item_t pending_q[$];
    nearest_t      nearest_q[$];
    element_item_t held_item;

    // Predictor copy of the stores and registers
    logic signed [VALUE_W-1:0] centroid_mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0] query_mem [MAX_DIM_DEF];
    logic [NCLUST_W-1:0]       cluster_count_reg = 7'd1;
    logic [VLEN_W-1:0]         vector_length_reg = 9'd256;

    // Entries already queued for writing, so that a search never reads a blank entry
    bit centroid_seen [TABLE_DEPTH];
    bit query_seen [MAX_DIM_DEF];
    bit steady_flow = 1'b0;

    int unsigned queued_items   = 0;
    int unsigned accepted_items = 0;
    int unsigned searches       = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned settings       = 0;
    int unsigned cycle_count    = 0;
    int unsigned widest_nc      = 0;
    int unsigned longest_len    = 0;

    always #5 aclk = ~aclk;

    function automatic bit stall_now();
        return !steady_flow && ($urandom_range(0, 99) < 18);
    endfunction

    function automatic logic [DIST_W-1:0] squared_distance(input int unsigned cluster,
                                                           input int unsigned len);
        longint unsigned acc;
        longint unsigned mag;
        int              diff;
        acc = 0;
        for (int d = 0; d < len; d++) begin
            diff = int'(query_mem[d]) - int'(centroid_mem[cluster * MAX_DIM_DEF + d]);
            mag  = (diff < 0) ? -diff : diff;
            acc  = acc + mag * mag;
            // hold at the top of the distance range
            if (acc > DIST_MAX)
                acc = DIST_MAX;
        end
        return acc[DIST_W-1:0];
    endfunction

    task automatic predict_item(input element_item_t it);
        int unsigned       ncs;
        int unsigned       lens;
        int unsigned       best;
        logic [DIST_W-1:0] best_d;
        logic [DIST_W-1:0] d_k;
        nearest_t          want;
        if (it.op == OP_CENTROID) begin
            centroid_mem[{it.cluster, it.element}] = it.value;
        end else begin
            query_mem[it.element] = it.value;
            if (it.last) begin
                ncs    = (cluster_count_reg > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF
                                                                : cluster_count_reg;
                lens   = (vector_length_reg > MAX_DIM_DEF) ? MAX_DIM_DEF : vector_length_reg;
                best   = 0;
                best_d = '0;
                if (ncs >= 1) begin
                    best_d = squared_distance(0, lens);
                    // strict compare: ties keep the lower index
                    for (int k = 1; k < ncs; k++) begin
                        d_k = squared_distance(k, lens);
                        if (d_k < best_d) begin
                            best_d = d_k;
                            best   = k;
                        end
                    end
                end
                want.cluster  = best[CLUSTER_W-1:0];
                want.distance = best_d;
                nearest_q.push_back(want);
                searches++;
            end
        end
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] beat);
        nearest_t want;
        results_seen++;
        if (nearest_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result with nothing pending: cluster %0d distance %0d",
                         beat[CLUSTER_W-1:0], beat[CLUSTER_W+DIST_W-1:CLUSTER_W]);
        end else begin
            want = nearest_q.pop_front();
            if (beat[CLUSTER_W-1:0] !== want.cluster ||
                beat[CLUSTER_W+DIST_W-1:CLUSTER_W] !== want.distance) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result %0d: expected cluster %0d distance %0d, ",
                              "got cluster %0d distance %0d"},
                             results_seen, want.cluster, want.distance,
                             beat[CLUSTER_W-1:0], beat[CLUSTER_W+DIST_W-1:CLUSTER_W]);
            end
        end
    endtask

    // Input driver: present the next pending item once the slot is free
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_item(held_item);
                accepted_items++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_q.size() != 0 && !stall_now()) begin
                    held_item = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, held_item.value, held_item.element, held_item.cluster};
                    s_tuser  <= held_item.op;
                    s_tlast  <= held_item.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            m_tready <= !stall_now();
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("run did not finish within %0d cycles", LIMIT_CYCLES);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            // small values make equal distances likely
            2, 3:    return 16'($urandom_range(0, 8) - 4);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic push_item(input logic op, input int unsigned cluster,
                             input int unsigned element, input logic [VALUE_W-1:0] value,
                             input logic last);
        element_item_t it;
        it.op      = op;
        it.cluster = cluster[CLUSTER_W-1:0];
        it.element = element[ELEMENT_W-1:0];
        it.value   = value;
        it.last    = last;
        pending_q.push_back(it);
        queued_items++;
        if (op == OP_CENTROID)
            centroid_seen[cluster * MAX_DIM_DEF + element] = 1'b1;
        else
            query_seen[element] = 1'b1;
    endtask

    // Wait until every item is taken and every result is back, then let the block go quiet
    task automatic settle();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || nearest_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input int unsigned value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= addr;
        cfg_wr_data <= value[CFG_DATA_W-1:0];
        if (addr == CFG_CLUSTER_COUNT)
            cluster_count_reg = value[NCLUST_W-1:0];
        else
            vector_length_reg = value[VLEN_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(input int unsigned nc, input int unsigned len);
        settle();
        write_reg(CFG_CLUSTER_COUNT, nc);
        write_reg(CFG_VECTOR_LENGTH, len);
        settings++;
        if (nc > widest_nc)
            widest_nc = (nc > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : nc;
        if (len > longest_len)
            longest_len = (len > MAX_DIM_DEF) ? MAX_DIM_DEF : len;
        // queue items away from the clock edge
        @(negedge aclk);
    endtask

    // One query: fill what the search needs, add stray traffic, then the query elements
    task automatic run_search();
        int unsigned ncs;
        int unsigned lens;
        int unsigned pick;
        int unsigned swap;
        int unsigned order [MAX_DIM_DEF];
        bit          reuse;
        ncs  = (cluster_count_reg > MAX_CLUSTERS_DEF) ? MAX_CLUSTERS_DEF : cluster_count_reg;
        lens = (vector_length_reg > MAX_DIM_DEF) ? MAX_DIM_DEF : vector_length_reg;
        for (int k = 0; k < ncs; k++)
            for (int d = 0; d < lens; d++)
                if (!centroid_seen[k * MAX_DIM_DEF + d])
                    push_item(OP_CENTROID, k, d, pick_value(), $urandom_range(0, 3) == 0);
        if (ncs != 0 && lens != 0) begin
            repeat ($urandom_range(0, 3))
                push_item(OP_CENTROID, $urandom_range(0, ncs - 1), $urandom_range(0, lens - 1),
                          pick_value(), $urandom_range(0, 3) == 0);
        end
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) == 0)
                push_item(OP_CENTROID, $urandom_range(0, 63), $urandom_range(0, 255),
                          pick_value(), $urandom_range(0, 1) == 1);
            else
                push_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 255),
                          pick_value(), 1'b0);
        end
        reuse = 1'b1;
        for (int d = 0; d < lens; d++)
            if (!query_seen[d])
                reuse = 1'b0;
        if (lens == 0 || (reuse && $urandom_range(0, 3) == 0)) begin
            // touch a few elements of the stored query and search again
            repeat ($urandom_range(0, 3))
                push_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 255),
                          pick_value(), 1'b0);
            push_item(OP_QUERY, $urandom_range(0, 63), $urandom_range(0, 255),
                      pick_value(), 1'b1);
        end else begin
            for (int i = 0; i < lens; i++)
                order[i] = i;
            for (int i = lens - 1; i > 0; i--) begin
                pick        = $urandom_range(0, i);
                swap        = order[i];
                order[i]    = order[pick];
                order[pick] = swap;
            end
            for (int i = 0; i < lens; i++)
                push_item(OP_QUERY, $urandom_range(0, 63), order[i], pick_value(), i == lens - 1);
        end
    endtask

    initial begin
        int unsigned nc;
        int unsigned len;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Four clusters of four: 0 and 2 equal at full scale, 1 at negative full scale, 3 zero
        set_config(4, 4);
        for (int k = 0; k < 4; k++)
            for (int d = 0; d < 4; d++)
                push_item(OP_CENTROID, k, d,
                          (k == 1) ? 16'h8000 : (k == 3) ? 16'h0000 : 16'h7FFF,
                          k == 2 && d == 3);
        for (int d = 0; d < 4; d++)
            push_item(OP_QUERY, 63, d, 16'h7FFF, d == 3);
        for (int d = 0; d < 4; d++)
            push_item(OP_QUERY, 0, d, 16'h8000, d == 3);
        push_item(OP_QUERY, 21, 255, 16'h5555, 1'b0);

        // no clusters, no length at full cluster count, a single cluster
        set_config(0, 4);
        run_search();
        set_config(64, 0);
        run_search();
        set_config(1, 4);
        run_search();

        // cluster count past the table, with both sides flowing freely
        steady_flow = 1'b1;
        set_config(127, 2);
        run_search();
        run_search();
        settle();
        steady_flow = 1'b0;

        // whole vectors, then a length register past the table
        set_config(1, 256);
        run_search();
        set_config(1, 511);
        run_search();

        while (queued_items < ITEM_TARGET) begin
            case ($urandom_range(0, 9))
                0: begin
                    nc  = $urandom_range(65, 127);
                    len = $urandom_range(0, 2);
                end
                1: begin
                    nc  = $urandom_range(0, 1);
                    len = $urandom_range(0, 16);
                end
                default: begin
                    len = $urandom_range(1, 8);
                    nc  = $urandom_range(2, 64 / len);
                end
            endcase
            set_config(nc, len);
            repeat ($urandom_range(2, 6))
                run_search();
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Streamed %0d items, %0d searches predicted, %0d results checked, %0d settings",
                 accepted_items, searches, results_seen, settings);
        $display({"Up to %0d centroids and %0d elements, ",
                  "with ties, zero sizes and clamped registers"},
                 widest_nc, longest_len);
        if (mismatches == 0 && nearest_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/ncs_pkg.sv
hdl/nearest_centroid_search.sv
sim/nearest_centroid_search_tb.sv
